FILE: src/pnpm_pkg.sv
package pnpm_pkg;

    // point coordinate width
    localparam int COORD_BITS = 16;

    // configuration register widths
    localparam int CFG_W     = 20;
    localparam int TGT_W     = 12;
    localparam int RAD_W     = 8;
    localparam int REG_IDX_W = 3;

    // shared multiplier operands: unsigned 20-bit intrinsics or signed coordinates
    localparam int OPA_W  = ((CFG_W > COORD_BITS) ? CFG_W : COORD_BITS) + 1;
    localparam int OPB_W  = COORD_BITS + 1;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = PROD_W + 1;

    // intrinsics carry 8 fraction bits
    localparam int FRAC_W = 8;

    // serial divider, two quotient bits per cycle
    localparam int MAG_W     = ACC_W - 1 - FRAC_W;
    localparam int DVD_W     = MAG_W + (MAG_W % 2);
    localparam int DVS_W     = COORD_BITS - 1;
    localparam int DIV_STEPS = DVD_W / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // projected pixel and window bounds
    localparam int COL_W = DVD_W + 1;
    localparam int WIN_W = TGT_W + 2;

    // squared distance
    localparam int DIST_W = 32;

    // stream payload width, whole bytes
    localparam int DATA_W = ((3 * COORD_BITS + 7) / 8) * 8;

    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(5);

    // register indexes on the configuration channel
    typedef enum logic [REG_IDX_W-1:0] {
        REG_FOCAL_X     = 3'd0,
        REG_FOCAL_Y     = 3'd1,
        REG_PRINCIPAL_X = 3'd2,
        REG_PRINCIPAL_Y = 3'd3,
        REG_TARGET_X    = 3'd4,
        REG_TARGET_Y    = 3'd5,
        REG_RADIUS      = 3'd6
    } reg_idx_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: src/pnpm_div.sv
module pnpm_div
    import pnpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;

    logic [DVS_W:0]    r1, r2, rm1, rm2;
    logic              ge1, ge2;

    // two restoring steps per cycle
    always_comb
    begin
        r1  = {rem_reg, quo_reg[DVD_W-1]};
        ge1 = (r1 >= {1'b0, dvs_reg});
        rm1 = ge1 ? (r1 - {1'b0, dvs_reg}) : r1;
        r2  = {rm1[DVS_W-1:0], quo_reg[DVD_W-2]};
        ge2 = (r2 >= {1'b0, dvs_reg});
        rm2 = ge2 ? (r2 - {1'b0, dvs_reg}) : r2;
    end

    // sequencing of the iterations
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DIV_STEPS - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_W-3:0], ge1, ge2};
            rem_next = rm2[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: src/pinhole_nearest_point_match_top.sv
// Nearest point search over a point cloud through a pinhole camera model.
// Slave stream: one point per request, x/y/z in s_tdata, s_tlast marks the
// last point of a scan. Master stream: one result per scan, the best point
// in m_tdata and the found flag in m_tuser. Intrinsics, target pixel and
// radius are to be written on the cfg channel while no point is in flight;
// the block itself does not enforce it. Each point is worked through one
// shared multiplier and one serial divider that yields two quotient bits
// per cycle, so s_tready drops after a request:
//   depth zero or below: straight to the final state
//   column outside the window: column products, division and window check
//   row outside the window: the column steps, then those of the row
//   point inside the window: both axes, then squared distance and update
// The result of a last point is in the output register when s_tready
// returns. If the receiver stalls, that result waits and points keep
// flowing; only a further last point waits in its final cycle until the
// register is free. Reset clears the search, drops m_tvalid and sets the
// configuration registers to zero except the radius, which comes up as 5.
module pinhole_nearest_point_match_top
    import pnpm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // point_x, point_y, point_z
    input  logic                 s_tlast,   // last_point
    // master stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // hit_x, hit_y, hit_z
    output logic                 m_tuser,   // found
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_MULA  = 13'b0000000000010,
        ST_MULB  = 13'b0000000000100,
        ST_SUMN  = 13'b0000000001000,
        ST_DIVGO = 13'b0000000010000,
        ST_DIVW  = 13'b0000000100000,
        ST_WIN   = 13'b0000001000000,
        ST_SQX   = 13'b0000010000000,
        ST_SQY   = 13'b0000100000000,
        ST_SQZ   = 13'b0001000000000,
        ST_SQS   = 13'b0010000000000,
        ST_UPD   = 13'b0100000000000,
        ST_FIN   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [CFG_W-1:0] focal_x_reg, focal_y_reg, principal_x_reg, principal_y_reg;
    logic [TGT_W-1:0] target_x_reg, target_y_reg;
    logic [RAD_W-1:0] radius_reg;

    // current point
    coord_t x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic   last_reg, last_next;
    logic   axis_reg, axis_next;

    // datapath
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [COL_W-1:0]  col_reg, col_next;
    logic                     neg_reg, neg_next;

    // search state
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    coord_t            best_x_reg, best_x_next, best_y_reg, best_y_next;
    coord_t            best_z_reg, best_z_next;
    logic              any_reg, any_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_found_reg, out_found_next;

    logic signed [OPA_W-1:0] mul_a;
    logic signed [OPB_W-1:0] mul_b;
    logic [ACC_W-1:0]        mag;
    logic signed [WIN_W-1:0] tgt_s, rad_s, win_lo, win_hi;
    logic                    win_ok;
    logic [DIST_W-1:0]       dist_sat;
    logic [CFG_W-1:0]        focal_sel, principal_sel;
    logic [TGT_W-1:0]        target_sel;
    coord_t                  coord_sel;
    coord_t                  s_x, s_y, s_z;
    logic                    s_fire;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    assign s_x    = s_tdata[COORD_BITS-1:0];
    assign s_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign s_z    = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign s_fire = s_tvalid && s_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_found_reg;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg     <= '0;
            focal_y_reg     <= '0;
            principal_x_reg <= '0;
            principal_y_reg <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            radius_reg      <= RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FOCAL_X:     focal_x_reg     <= cfg_data;
                REG_FOCAL_Y:     focal_y_reg     <= cfg_data;
                REG_PRINCIPAL_X: principal_x_reg <= cfg_data;
                REG_PRINCIPAL_Y: principal_y_reg <= cfg_data;
                REG_TARGET_X:    target_x_reg    <= cfg_data[TGT_W-1:0];
                REG_TARGET_Y:    target_y_reg    <= cfg_data[TGT_W-1:0];
                REG_RADIUS:      radius_reg      <= cfg_data[RAD_W-1:0];
                default:         ;
            endcase
        end
    end

    // axis selection
    assign focal_sel     = axis_reg ? focal_y_reg : focal_x_reg;
    assign principal_sel = axis_reg ? principal_y_reg : principal_x_reg;
    assign target_sel    = axis_reg ? target_y_reg : target_x_reg;
    assign coord_sel     = axis_reg ? y_reg : x_reg;

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MULA:
            begin
                mul_a = OPA_W'(signed'({1'b0, focal_sel}));
                mul_b = OPB_W'(coord_sel);
            end
            ST_MULB:
            begin
                mul_a = OPA_W'(signed'({1'b0, principal_sel}));
                mul_b = OPB_W'(z_reg);
            end
            ST_SQX:
            begin
                mul_a = OPA_W'(x_reg);
                mul_b = OPB_W'(x_reg);
            end
            ST_SQY:
            begin
                mul_a = OPA_W'(y_reg);
                mul_b = OPB_W'(y_reg);
            end
            ST_SQZ:
            begin
                mul_a = OPA_W'(z_reg);
                mul_b = OPB_W'(z_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // numerator magnitude for the divider
    assign mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    always_comb
    begin
        div_req.start    = (state_reg == ST_DIVGO);
        div_req.dividend = DVD_W'(mag[ACC_W-2:FRAC_W]);
        div_req.divisor  = z_reg[DVS_W-1:0];
    end

    pnpm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // window bounds: target minus radius < pixel < target plus radius
    always_comb
    begin
        tgt_s  = WIN_W'({1'b0, target_sel});
        rad_s  = WIN_W'({1'b0, radius_reg});
        win_lo = tgt_s - rad_s;
        win_hi = tgt_s + rad_s;
        win_ok = (col_reg > COL_W'(win_lo)) && (col_reg < COL_W'(win_hi));
    end

    // squared distance, saturated
    assign dist_sat = (|acc_reg[ACC_W-1:DIST_W]) ? '1 : acc_reg[DIST_W-1:0];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        last_next      = last_reg;
        axis_next      = axis_reg;
        acc_next       = acc_reg;
        col_next       = col_reg;
        neg_next       = neg_reg;
        best_dist_next = best_dist_reg;
        best_x_next    = best_x_reg;
        best_y_next    = best_y_reg;
        best_z_next    = best_z_reg;
        any_next       = any_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_found_next = out_found_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    x_next    = s_x;
                    y_next    = s_y;
                    z_next    = s_z;
                    last_next = s_tlast;
                    axis_next = 1'b0;
                    if (!s_z[COORD_BITS-1] && (s_z != '0))
                        state_next = ST_MULA;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_MULA:
                state_next = ST_MULB;
            ST_MULB:
            begin
                acc_next   = ACC_W'(prod_reg);
                state_next = ST_SUMN;
            end
            ST_SUMN:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                neg_next   = acc_reg[ACC_W-1];
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (div_rsp.done)
                begin
                    col_next   = neg_reg ? -signed'({1'b0, div_rsp.quotient})
                                         :  signed'({1'b0, div_rsp.quotient});
                    state_next = ST_WIN;
                end
            end
            ST_WIN:
            begin
                if (!win_ok)
                    state_next = ST_FIN;
                else if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = ST_MULA;
                end
                else
                    state_next = ST_SQX;
            end
            ST_SQX:
                state_next = ST_SQY;
            ST_SQY:
            begin
                acc_next   = ACC_W'(prod_reg);
                state_next = ST_SQZ;
            end
            ST_SQZ:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = ST_SQS;
            end
            ST_SQS:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                // first match always taken, later ones only when strictly closer
                if (!any_reg || (dist_sat < best_dist_reg))
                begin
                    best_dist_next = dist_sat;
                    best_x_next    = x_reg;
                    best_y_next    = y_reg;
                    best_z_next    = z_reg;
                    any_next       = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = any_reg;
                    out_data_next  = DATA_W'({best_z_reg, best_y_reg, best_x_reg});
                    best_dist_next = '1;
                    best_x_next    = '0;
                    best_y_next    = '0;
                    best_z_next    = '0;
                    any_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control and search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            best_dist_reg <= '1;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            best_z_reg    <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            best_dist_reg <= best_dist_next;
            best_x_reg    <= best_x_next;
            best_y_reg    <= best_y_next;
            best_z_reg    <= best_z_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        last_reg      <= last_next;
        axis_reg      <= axis_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        col_reg       <= col_next;
        neg_reg       <= neg_next;
        out_data_reg  <= out_data_next;
        out_found_reg <= out_found_next;
    end

endmodule

FILE: src/pnpm_chk.sv
module pnpm_chk
    import pnpm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [DATA_W-1:0]    s_tdata,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [DATA_W-1:0]    m_tdata,
    input logic                 m_tuser,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [REG_IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]     cfg_data
);

    // the block works on one point at a time
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a point is in progress");

    // an empty scan reports a zero point
    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata == '0))
        else $error("empty scan result carries a point");

    // a found point always has positive depth
    a_found_depth: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            !m_tdata[3*COORD_BITS-1] && (m_tdata[3*COORD_BITS-1:2*COORD_BITS] != '0))
        else $error("found point with depth zero or below");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind pinhole_nearest_point_match_top pnpm_chk u_pnpm_chk (.*);
